### rtl/core/n7s_pkg.sv
// Shared constants and the glyph decoder for the seven-segment number formatter.
// Used by n7s_div and number_to_seven_segment_formatter; depends on nothing.
package n7s_pkg;

	localparam int MAG_W    = 32;
	localparam int BASE_W   = 5;
	localparam int DIGIT_W  = 4;
	localparam int FRAC_W   = 2;
	localparam int FRAC_MAX = 3;
	localparam int FACT_W   = DIGIT_W * FRAC_MAX + 1;
	localparam int SEG_W    = 8;

	localparam int DIGIT_COUNT_DEF   = 4;
	localparam int FRACTION_BITS_DEF = 16;

	localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
	localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;

	localparam logic [SEG_W-1:0] SEG_DASH  = 8'h40;
	localparam logic [SEG_W-1:0] SEG_DOT   = 8'h80;
	localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

	// segments a-g in bits 0-6, hex digits lower/upper case as usual on such displays
	function automatic logic [SEG_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] g;
		unique case (d)
			4'h0: g = 8'h3F;
			4'h1: g = 8'h06;
			4'h2: g = 8'h5B;
			4'h3: g = 8'h4F;
			4'h4: g = 8'h66;
			4'h5: g = 8'h6D;
			4'h6: g = 8'h7D;
			4'h7: g = 8'h07;
			4'h8: g = 8'h7F;
			4'h9: g = 8'h6F;
			4'hA: g = 8'h77;
			4'hB: g = 8'h7C;
			4'hC: g = 8'h39;
			4'hD: g = 8'h5E;
			4'hE: g = 8'h79;
			4'hF: g = 8'h71;
		endcase
		return g;
	endfunction

endpackage

### rtl/core/n7s_mul.sv
// Shared registered multiplier for the number formatter.
// Used for the radix power table and for scaling the magnitude; no package needed.
module n7s_mul #(
	parameter int A_W = 32,
	parameter int B_W = 13
) (
	input  logic                 clk,
	input  logic [A_W-1:0]       a,
	input  logic [B_W-1:0]       b,
	output logic [A_W+B_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
	end

endmodule

### rtl/core/n7s_div.sv
// Radix divide step: four quotient bits per call of a restoring divide by the base.
// Depends on n7s_pkg for widths.
module n7s_div (
	input  logic [n7s_pkg::DIGIT_W-1:0] rem_in,
	input  logic [n7s_pkg::DIGIT_W-1:0] bits_in,
	input  logic [n7s_pkg::BASE_W-1:0]  base,
	output logic [n7s_pkg::DIGIT_W-1:0] rem_out,
	output logic [n7s_pkg::DIGIT_W-1:0] quo
);

	always_comb begin
		logic [n7s_pkg::DIGIT_W:0]   part;
		logic [n7s_pkg::DIGIT_W-1:0] r;
		r = rem_in;
		quo = '0;
		part = '0;
		for (int j = n7s_pkg::DIGIT_W - 1; j >= 0; j--) begin
			part = {r, bits_in[j]};
			if (part >= base) begin
				part = part - base;
				quo[j] = 1'b1;
			end
			// remainder stays below the base, so it fits one digit
			r = part[n7s_pkg::DIGIT_W-1:0];
		end
		rem_out = r;
	end

endmodule

### rtl/core/number_to_seven_segment_formatter.sv
// Top level of the seven-segment number formatter: sequencer, scaling and digit loop.
// Depends on n7s_pkg, n7s_mul and n7s_div.
//
// Use: pulse start with value (signed, FRACTION_BITS fraction bits) and
// frac_digits while busy is low; the word is taken at that edge and busy rises.
// When the display is ready, done is high for exactly one cycle with
// segments_0..segments_3 (left to right) and overflow_error; the receiver must
// take it then, it cannot hold the block off. busy is low again in that cycle.
// The user writes number_base via number_base_we only while idle; not enforced by the block.
// Sequence: the radix powers are built on the shared multiplier, then scaling trials
// run (1 to 4 trials as fraction digits are dropped), then the digits come from the
// divide unit (4 quotient bits a cycle; a lone zero skips it) and the sign step
// finishes, or done is raised straight from the check on overflow. One item is in
// flight at a time. Reset sets the base to 10, clears busy and done.
module number_to_seven_segment_formatter #(
	parameter int DIGIT_COUNT   = n7s_pkg::DIGIT_COUNT_DEF,
	parameter int FRACTION_BITS = n7s_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [n7s_pkg::MAG_W-1:0]  value,
	input  logic [n7s_pkg::FRAC_W-1:0]        frac_digits,
	input  logic                              number_base_we,
	input  logic [n7s_pkg::BASE_W-1:0]        number_base,
	output logic                              done,
	output logic [n7s_pkg::SEG_W-1:0]         segments_0,
	output logic [n7s_pkg::SEG_W-1:0]         segments_1,
	output logic [n7s_pkg::SEG_W-1:0]         segments_2,
	output logic [n7s_pkg::SEG_W-1:0]         segments_3,
	output logic                              overflow_error
);

	localparam int KMAX    = (DIGIT_COUNT > n7s_pkg::FRAC_MAX) ? DIGIT_COUNT
	                                                            : n7s_pkg::FRAC_MAX;
	localparam int P_W     = n7s_pkg::DIGIT_W * KMAX + 1;
	localparam int A_W     = (P_W > n7s_pkg::MAG_W) ? P_W : n7s_pkg::MAG_W;
	localparam int PROD_W  = A_W + n7s_pkg::FACT_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int D_W     = n7s_pkg::DIGIT_W * DIGIT_COUNT;
	localparam int K_W     = $clog2(KMAX + 1);
	localparam int IMAX    = (DIGIT_COUNT > n7s_pkg::FRAC_MAX + 1) ? DIGIT_COUNT
	                                                                : n7s_pkg::FRAC_MAX + 1;
	localparam int I_W     = $clog2(IMAX + 1);
	localparam int POS_W   = $clog2(DIGIT_COUNT);
	localparam int C_W     = $clog2(DIGIT_COUNT);
	localparam int HALF_SH = (FRACTION_BITS > 0) ? FRACTION_BITS - 1 : 0;
	localparam logic [SUM_W-1:0] HALF = (FRACTION_BITS > 0) ? (SUM_W'(1) << HALF_SH) : '0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POW,
		ST_SCALE,
		ST_CHECK,
		ST_DIV,
		ST_SIGN
	} state_t;

	state_t                         state_q;
	logic                           done_q;
	logic                           err_q;
	logic [n7s_pkg::BASE_W-1:0]     base_q;
	logic [K_W-1:0]                 k_q;
	logic [C_W-1:0]                 cnt_q;
	logic [I_W-1:0]                 i_q;
	logic [POS_W-1:0]               pos_q;
	logic                           pos_ok_q;
	logic                           neg_q;
	logic [n7s_pkg::FRAC_W-1:0]     frac_q;

	logic [n7s_pkg::BASE_W-1:0]     ubase_q;
	logic [n7s_pkg::MAG_W-1:0]      mag_q;
	logic [n7s_pkg::FACT_W-1:0]     pw_q [n7s_pkg::FRAC_MAX];
	logic [P_W-1:0]                 limit_q;
	logic [D_W-1:0]                 dq_q;
	logic [n7s_pkg::DIGIT_W-1:0]    rem_q;
	logic [n7s_pkg::SEG_W-1:0]      disp_q [DIGIT_COUNT];

	logic [n7s_pkg::BASE_W-1:0]     base_use;
	logic [n7s_pkg::FACT_W-1:0]     factor;
	logic [A_W-1:0]                 mul_a;
	logic [n7s_pkg::FACT_W-1:0]     mul_b;
	logic [PROD_W-1:0]              prod_q;
	logic [SUM_W-1:0]               num;
	logic                           fits;
	logic                           num_zero;
	logic [K_W-1:0]                 avail;
	logic [n7s_pkg::DIGIT_W-1:0]    rem_nx;
	logic [n7s_pkg::DIGIT_W-1:0]    quo;
	logic [D_W-1:0]                 dq_nx;
	logic                           div_last;
	logic                           more;
	logic                           dot;
	logic [n7s_pkg::SEG_W-1:0]      digit_pat;
	logic [n7s_pkg::SEG_W-1:0]      shown [4];

	// clamp the written base into 2..16
	always_comb begin
		if (base_q < n7s_pkg::BASE_MIN)
			base_use = n7s_pkg::BASE_MIN;
		else if (base_q > n7s_pkg::BASE_MAX)
			base_use = n7s_pkg::BASE_MAX;
		else
			base_use = base_q;
	end

	assign factor = (frac_q == '0) ? n7s_pkg::FACT_W'(1)
	                               : pw_q[n7s_pkg::FRAC_W'(frac_q - 1'b1)];

	always_comb begin
		if (state_q == ST_POW) begin
			mul_a = (k_q == '0) ? A_W'(1) : A_W'(prod_q[P_W-1:0]);
			mul_b = n7s_pkg::FACT_W'(ubase_q);
		end else begin
			mul_a = A_W'(mag_q);
			mul_b = factor;
		end
	end

	n7s_mul #(
		.A_W (A_W),
		.B_W (n7s_pkg::FACT_W)
	) u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// round half up, then drop the fraction bits
	assign num      = (SUM_W'(prod_q) + HALF) >> FRACTION_BITS;
	assign fits     = num < SUM_W'(limit_q);
	assign num_zero = (num == '0);
	assign avail    = neg_q ? K_W'(DIGIT_COUNT - 1) : K_W'(DIGIT_COUNT);

	n7s_div u_div (
		.rem_in  (rem_q),
		.bits_in (dq_q[D_W-1 -: n7s_pkg::DIGIT_W]),
		.base    (ubase_q),
		.rem_out (rem_nx),
		.quo     (quo)
	);

	assign dq_nx     = {dq_q[D_W-n7s_pkg::DIGIT_W-1:0], quo};
	assign div_last  = (cnt_q == C_W'(DIGIT_COUNT - 1));
	assign more      = (dq_nx != '0) || (I_W'(i_q + 1'b1) <= I_W'(frac_q));
	assign dot       = (frac_q != '0) && (i_q == I_W'(frac_q));
	assign digit_pat = n7s_pkg::glyph(rem_nx) | (dot ? n7s_pkg::SEG_DOT : n7s_pkg::SEG_BLANK);

	// sequencer, counters and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			err_q    <= 1'b0;
			base_q   <= n7s_pkg::BASE_RESET;
			k_q      <= '0;
			cnt_q    <= '0;
			i_q      <= '0;
			pos_q    <= '0;
			pos_ok_q <= 1'b0;
			neg_q    <= 1'b0;
			frac_q   <= '0;
		end else begin
			// raise done after the sign step or on overflow
			done_q <= (state_q == ST_SIGN) ||
			          ((state_q == ST_CHECK) && !fits && (frac_q == '0));
			if (number_base_we)
				base_q <= number_base;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_POW;
						k_q     <= '0;
						neg_q   <= value[n7s_pkg::MAG_W-1];
						frac_q  <= frac_digits;
						err_q   <= 1'b0;
					end
				end
				ST_POW: begin
					k_q <= k_q + 1'b1;
					if (k_q == K_W'(KMAX))
						state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (fits) begin
						i_q      <= '0;
						cnt_q    <= '0;
						pos_ok_q <= 1'b1;
						if (num_zero) begin
							// lone zero takes the rightmost place
							pos_q   <= POS_W'(DIGIT_COUNT - 2);
							state_q <= ST_SIGN;
						end else begin
							pos_q   <= POS_W'(DIGIT_COUNT - 1);
							state_q <= ST_DIV;
						end
					end else if (frac_q == '0) begin
						err_q   <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						// drop one fraction digit and rescale
						frac_q  <= frac_q - 1'b1;
						state_q <= ST_SCALE;
					end
				end
				ST_DIV: begin
					if (div_last) begin
						cnt_q <= '0;
						i_q   <= i_q + 1'b1;
						if (pos_q == '0)
							pos_ok_q <= 1'b0;
						else
							pos_q <= pos_q - 1'b1;
						if (!more)
							state_q <= ST_SIGN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SIGN: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ubase_q <= base_use;
					mag_q   <= value[n7s_pkg::MAG_W-1] ? n7s_pkg::MAG_W'(~value + 1'b1)
					                                   : n7s_pkg::MAG_W'(value);
					for (int p = 0; p < DIGIT_COUNT; p++)
						disp_q[p] <= n7s_pkg::SEG_BLANK;
				end
			end
			ST_POW: begin
				// prod_q holds base^k_q here once k_q is nonzero
				if (k_q == avail)
					limit_q <= prod_q[P_W-1:0];
				if (k_q != '0 && k_q <= K_W'(n7s_pkg::FRAC_MAX))
					pw_q[n7s_pkg::FRAC_W'(k_q - 1'b1)] <= prod_q[n7s_pkg::FACT_W-1:0];
			end
			ST_CHECK: begin
				if (fits) begin
					dq_q  <= num[D_W-1:0];
					rem_q <= '0;
					if (num_zero)
						disp_q[DIGIT_COUNT-1] <= n7s_pkg::glyph(n7s_pkg::DIGIT_W'(0));
				end else if (frac_q == '0) begin
					for (int p = 0; p < DIGIT_COUNT; p++)
						disp_q[p] <= n7s_pkg::SEG_DASH;
				end
			end
			ST_DIV: begin
				dq_q  <= dq_nx;
				rem_q <= div_last ? '0 : rem_nx;
				if (div_last && pos_ok_q)
					disp_q[pos_q] <= digit_pat;
			end
			ST_SIGN: begin
				if (neg_q && pos_ok_q)
					disp_q[pos_q] <= n7s_pkg::SEG_DASH;
			end
			default: ;
		endcase
	end

	for (genvar g = 0; g < 4; g++) begin : g_shown
		if (g < DIGIT_COUNT) begin : g_on
			assign shown[g] = disp_q[g];
		end else begin : g_off
			assign shown[g] = n7s_pkg::SEG_BLANK;
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign overflow_error = err_q;
	assign segments_0     = shown[0];
	assign segments_1     = shown[1];
	assign segments_2     = shown[2];
	assign segments_3     = shown[3];

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_err_dashes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow_error) |-> (segments_0 == n7s_pkg::SEG_DASH))
		else $error("overflow without dash pattern");

	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> ({1'b0, rem_q} < ubase_q))
		else $error("divide remainder reached the base");

endmodule
